FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the console writer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define AST_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");

// Condition that must never hold.
`define AST_NEVER(lbl, clk, rst_n, cond) \
	`AST_CLK(lbl, clk, rst_n, !(cond))

`endif

FILE: rtl/core/tcw_pkg.sv
// Package for the text console writer: geometry, request/result types, codes.
// No dependencies.
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int CELL_W  = $clog2(CELLS);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int POS_W   = 11;
	localparam int PADDR_W = 3;

	localparam logic       REQ_PUT      = 1'b0;
	localparam logic       REQ_READ     = 1'b1;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] ATTR_RESET   = 8'h07;
	localparam logic       REG_TEXT_ATTR = 1'b0;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  ch;
		logic [10:0] cell_index;
	} tcw_req_t;

	typedef struct packed {
		logic        cursor_valid;
		logic [10:0] cursor_pos;
		logic        scrolled;
		logic [15:0] read_data;
	} tcw_res_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCROLL
	} tcw_state_t;

endpackage

FILE: rtl/core/text_console_writer_unit.sv
// Text console writer: 80x25 cell store in one synchronous RAM, cursor and scroll control.
// Depends on tcw_pkg and assert_macros.svh.

// A put request (character or newline) is taken and its result is ready in the
// next cycle; a read request passes through ST_READ, since the cell store read
// is registered. A put that moves past the last row scrolls the
// screen: the RAM is swept once, one cell per cycle, copying each row up and
// zeroing the last, and no request is taken until the sweep has finished. After
// reset a clearing pass writes every cell to zero before the first request is
// taken. The result sits in an output register; while it waits no request is
// taken, and the next one can be taken in the cycle the waiting result is taken.
// Register writes are always taken.
`include "assert_macros.svh"

module text_console_writer_unit import tcw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  tcw_req_t           req_data,
	output logic               res_valid,
	input  logic               res_ready,
	output tcw_res_t           res_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [15:0] mem [CELLS];
	logic [15:0] mem_rd_q;
	logic        mem_we;
	logic [CELL_W-1:0] mem_wa;
	logic [15:0] mem_wd;
	logic [CELL_W-1:0] mem_ra;

	tcw_state_t state_q, state_d;
	logic [CELL_W-1:0] cnt_q;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [CELL_W-1:0] pos_q, pos_d;
	logic [7:0]        attr_q;
	logic              oor_q;
	logic              wv_s1, wz_s1;
	logic [CELL_W-1:0] wa_s1;
	logic              res_valid_q;
	tcw_res_t          res_q;

	logic req_accept, is_put, is_nl, col_last, row_last, do_scroll, cnt_last, sweep_zero;

	assign req_accept = req_valid & req_ready;
	assign is_put     = req_data.req_type == REQ_PUT;
	assign is_nl      = req_data.ch == NEWLINE_CODE;
	assign col_last   = col_q == COL_W'(COLUMNS - 1);
	assign row_last   = row_q == ROW_W'(ROWS - 1);
	assign do_scroll  = row_last & (is_nl | col_last);
	assign cnt_last   = cnt_q == CELL_W'(CELLS - 1);
	assign sweep_zero = 32'(cnt_q) >= (CELLS - COLUMNS);

	// cursor update for a put
	always_comb begin
		row_d = row_q;
		col_d = col_q;
		pos_d = pos_q;
		if (do_scroll) begin
			row_d = ROW_W'(ROWS - 1);
			col_d = '0;
			pos_d = CELL_W'((ROWS - 1) * COLUMNS);
		end else if (is_nl) begin
			row_d = row_q + 1'b1;
			col_d = '0;
			pos_d = pos_q - CELL_W'(col_q) + CELL_W'(COLUMNS);
		end else if (col_last) begin
			row_d = row_q + 1'b1;
			col_d = '0;
			pos_d = pos_q + 1'b1;
		end else begin
			col_d = col_q + 1'b1;
			pos_d = pos_q + 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_accept) begin
					if (!is_put) state_d = ST_READ;
					else if (do_scroll) state_d = ST_SCROLL;
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_SCROLL: begin
				if (cnt_last) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs: RAM controls and request ready
	always_comb begin
		mem_we    = 1'b0;
		mem_wa    = pos_q;
		mem_wd    = {attr_q, req_data.ch};
		mem_ra    = CELL_W'(req_data.cell_index);
		req_ready = 1'b0;
		if (wv_s1) begin
			mem_we = 1'b1;
			mem_wa = wa_s1;
			mem_wd = wz_s1 ? 16'h0000 : mem_rd_q;
		end
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = 16'h0000;
			end
			ST_IDLE: begin
				req_ready = !wv_s1 && (!res_valid_q || res_ready);
				if (req_accept && is_put && !is_nl) mem_we = 1'b1;
			end
			ST_SCROLL: begin
				mem_ra = sweep_zero ? '0 : CELL_W'(cnt_q + CELL_W'(COLUMNS));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			pos_q       <= '0;
			attr_q      <= ATTR_RESET;
			wv_s1       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR || state_q == ST_SCROLL)
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			wv_s1 <= state_q == ST_SCROLL;
			if (req_accept && is_put) begin
				row_q <= row_d;
				col_q <= col_d;
				pos_q <= pos_d;
			end
			if (psel && penable && pwrite && paddr[2] == REG_TEXT_ATTR)
				attr_q <= pwdata[7:0];
			if ((req_accept && is_put) || state_q == ST_READ)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		wa_s1 <= cnt_q;
		wz_s1 <= sweep_zero;
		if (req_accept) oor_q <= 32'(req_data.cell_index) >= CELLS;
		if (req_accept && is_put) begin
			res_q.cursor_valid <= !is_nl;
			res_q.cursor_pos   <= is_nl ? '0 : POS_W'(pos_q);
			res_q.scrolled     <= do_scroll;
			res_q.read_data    <= '0;
		end else if (state_q == ST_READ) begin
			res_q.cursor_valid <= 1'b0;
			res_q.cursor_pos   <= '0;
			res_q.scrolled     <= 1'b0;
			res_q.read_data    <= oor_q ? 16'h0000 : mem_rd_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_TEXT_ATTR) ? {24'h000000, attr_q} : 32'h0;

	`AST_NEVER(a_busy_no_req, clk, arst_n,
		(state_q == ST_CLEAR || state_q == ST_SCROLL || state_q == ST_READ) && req_ready)
	`AST_CLK(a_cursor_bounds, clk, arst_n,
		32'(row_q) < ROWS && 32'(col_q) < COLUMNS)
	`AST_CLK(a_pos_tracks, clk, arst_n,
		32'(pos_q) == 32'(row_q) * COLUMNS + 32'(col_q))
	`AST_CLK(a_read_path, clk, arst_n,
		(req_accept && !is_put) |=> (state_q == ST_READ && !res_valid_q))

endmodule

FILE: tb/sv/tb_text_console_writer_unit.sv
`timescale 1ns / 1ps
// Testbench for text_console_writer_unit: directed, then random put and read requests,
// each checked against an in-bench model of the cell store, cursor and scroll.
// Depends on tcw_pkg and the RTL only.
module tb_text_console_writer_unit;
	import tcw_pkg::*;

	localparam int RANDOM_PER_PHASE = 615;
	localparam int LONG_HOLD        = 300;
	localparam int DRAIN_CYCLES     = CELLS + 16;
	localparam int CYCLE_LIMIT      =
		4 * ((25 + 3 * RANDOM_PER_PHASE) * (CELLS + 41) + LONG_HOLD + 3 * CELLS);
	localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * int'(REG_TEXT_ATTR));

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	tcw_req_t           req_data  = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	tcw_res_t           res_data;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [31:0]        pwdata    = '0;
	logic [31:0]        prdata;
	logic               pready;

	tcw_req_t    pending_requests[$];
	tcw_res_t    expected_results[$];
	logic [15:0] shadow_cells [CELLS];
	int          cur_row;
	int          cur_col;
	logic [7:0]  shadow_attr;
	int          send_idle_pct    = 0;
	int          recv_idle_pct    = 0;
	int          long_holds_asked = 0;
	int          long_holds_done  = 0;
	int          hold_left        = 0;
	int          mismatch_count   = 0;
	int          cycle_count      = 0;

	text_console_writer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies one request to the console copy and returns the result it yields.
	function automatic tcw_res_t console_apply(tcw_req_t r);
		tcw_res_t o;
		int       cell_no;
		o = '0;
		if (r.req_type == REQ_READ) begin
			if (r.cell_index < CELLS)
				o.read_data = shadow_cells[r.cell_index];
		end else begin
			if (r.ch == NEWLINE_CODE) begin
				cur_row++;
				cur_col = 0;
			end else begin
				cell_no = cur_row * COLUMNS + cur_col;
				shadow_cells[cell_no] = {shadow_attr, r.ch};
				o.cursor_valid = 1'b1;
				o.cursor_pos   = POS_W'(cell_no);
				cur_col++;
				if (cur_col >= COLUMNS) begin
					cur_row++;
					cur_col = 0;
				end
			end
			if (cur_row >= ROWS) begin
				for (int i = 0; i < CELLS - COLUMNS; i++)
					shadow_cells[i] = shadow_cells[i + COLUMNS];
				for (int i = CELLS - COLUMNS; i < CELLS; i++)
					shadow_cells[i] = '0;
				cur_row = ROWS - 1;
				cur_col = 0;
				o.scrolled = 1'b1;
			end
		end
		return o;
	endfunction

	function automatic tcw_req_t make_request(logic kind, logic [7:0] code, logic [10:0] index);
		tcw_req_t r;
		r.req_type   = kind;
		r.ch         = code;
		r.cell_index = index;
		return r;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Mostly characters with some newlines, so the screen fills and scrolls;
	// reads spread over the screen, the bottom rows and past the end.
	task automatic load_random_requests(int count);
		tcw_req_t r;
		int       pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99, 0);
			r.ch         = 8'($urandom_range(255, 0));
			r.cell_index = 11'($urandom_range(2047, 0));
			if (pick < 40) begin
				r.req_type = REQ_READ;
				if (pick < 8)
					r.cell_index = 11'($urandom_range(2047, CELLS));
				else if (pick < 20)
					r.cell_index = 11'($urandom_range(CELLS - 1, CELLS - 2 * COLUMNS));
				else
					r.cell_index = 11'($urandom_range(CELLS - 1, 0));
			end else begin
				r.req_type = REQ_PUT;
				if (pick < 45)
					r.ch = NEWLINE_CODE;
			end
			pending_requests.push_back(r);
		end
	endtask

	// checked after the edge's updates have settled
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pending_requests.size() > 0 || req_valid || expected_results.size() > 0);
	endtask

	task automatic write_attr(logic [7:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ATTR_ADDR;
		pwdata  <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow_attr = value;
	endtask

	always @(posedge clk) begin : request_driver
		if (arst_n) begin
			if (req_valid && req_ready)
				expected_results.push_back(console_apply(req_data));
			if (!req_valid || req_ready) begin
				if (pending_requests.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					req_data  <= pending_requests.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		tcw_res_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: 0x%0h", res_data);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("cursor_valid", 16'(want.cursor_valid), 16'(res_data.cursor_valid));
					check_field("cursor_pos", 16'(want.cursor_pos), 16'(res_data.cursor_pos));
					check_field("scrolled", 16'(want.scrolled), 16'(res_data.scrolled));
					check_field("read_data", want.read_data, res_data.read_data);
				end
			end
			// long hold-off so the output register fills and the input stalls
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (long_holds_done < long_holds_asked) begin
				long_holds_done++;
				hold_left = LONG_HOLD;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		foreach (shadow_cells[i])
			shadow_cells[i] = '0;
		cur_row       = 0;
		cur_col       = 0;
		shadow_attr   = ATTR_RESET;
		send_idle_pct = 26;
		recv_idle_pct = 84;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: cleared store, out-of-range reads, character extremes, newlines
		pending_requests.push_back(make_request(REQ_READ, 8'h00, 11'd0));
		pending_requests.push_back(make_request(REQ_READ, 8'h55, 11'(CELLS - 1)));
		pending_requests.push_back(make_request(REQ_READ, 8'hAA, 11'(CELLS)));
		pending_requests.push_back(make_request(REQ_READ, 8'hFF, 11'h7FF));
		pending_requests.push_back(make_request(REQ_PUT, 8'h01, 11'h000));
		pending_requests.push_back(make_request(REQ_PUT, 8'hFF, 11'h7FF));
		pending_requests.push_back(make_request(REQ_PUT, 8'h00, 11'h555));
		pending_requests.push_back(make_request(REQ_PUT, 8'h7F, 11'h2AA));
		pending_requests.push_back(make_request(REQ_PUT, 8'h80, 11'h000));
		pending_requests.push_back(make_request(REQ_PUT, NEWLINE_CODE, 11'h7FF));
		pending_requests.push_back(make_request(REQ_PUT, NEWLINE_CODE, 11'h000));
		pending_requests.push_back(make_request(REQ_PUT, 8'h41, 11'h3C0));
		pending_requests.push_back(make_request(REQ_READ, 8'h0A, 11'd0));
		pending_requests.push_back(make_request(REQ_READ, 8'h00, 11'd1));
		pending_requests.push_back(make_request(REQ_READ, 8'h00, 11'd2));
		pending_requests.push_back(make_request(REQ_READ, 8'h00, 11'd3));
		pending_requests.push_back(make_request(REQ_READ, 8'h00, 11'd4));
		pending_requests.push_back(make_request(REQ_READ, 8'h00, 11'd5));
		pending_requests.push_back(make_request(REQ_READ, 8'h00, 11'(2 * COLUMNS)));
		pending_requests.push_back(make_request(REQ_READ, 8'h00, 11'(2 * COLUMNS + 1)));
		pending_requests.push_back(make_request(REQ_READ, 8'hC3, 11'h555));
		wait_idle();

		write_attr(8'hFF);
		load_random_requests(RANDOM_PER_PHASE);
		wait_idle();

		write_attr(8'h00);
		send_idle_pct = 84;
		recv_idle_pct = 26;
		load_random_requests(RANDOM_PER_PHASE);
		wait_idle();

		write_attr(8'($urandom_range(254, 1)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_random_requests(RANDOM_PER_PHASE);
		long_holds_asked++;
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
